// ===== rtl/tche_pkg.sv =====
// Shared constants and helpers of the three-channel histogram engine.
// No dependencies; imported by the top level.
`default_nettype none
package tche_pkg;

  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 24;
  localparam int CHANNELS   = 3;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int EXT_W      = 9;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_W-1:0]      bin_t;
  typedef logic signed [EXT_W-1:0] ext_t;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_PIXEL    = 2'd1,
    OP_FINALIZE = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  localparam ext_t EMPTY_BIN = -9'sd1;

  // Clamp an 8-bit component or index to the last bin.
  function automatic bin_t bin_of(input logic [7:0] v);
    if (32'(v) >= NUM_BINS) begin
      return BIN_W'(NUM_BINS - 1);
    end
    return BIN_W'(v);
  endfunction

  // Add with saturation at the top count.
  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[COUNT_BITS]) begin
      return '1;
    end
    return s[COUNT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tche_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module tche_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/three_channel_histogram_engine_top.sv =====
// Top level of the three-channel histogram engine.
// Depends on tche_pkg and tche_ram.
`default_nettype none
// Keeps one histogram per colour channel in block RAM, three bin-count RAMs and
// three cumulative RAMs of NUM_BINS entries each. After reset and after every
// clear item the block sweeps all RAMs to zero, one entry per cycle, and takes
// no item meanwhile. A pixel item does a RAM read, then a saturating write-back
// of all three channels. A query reads the RAMs and yields one result transfer.
// A finalize item walks all channels in parallel through the bin RAMs, filling
// the cumulative RAMs and the min, max and peak statistics. Only a query
// produces a result; the input side accepts only while the result register is
// empty or is being taken.
module three_channel_histogram_engine_top
  import tche_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // comp_a[7:0], comp_b[15:8], comp_c[23:16], bin_index[31:24]
  input  wire logic [31:0]  in_tdata,
  // opcode[1:0], channel_sel[3:2]
  input  wire logic [3:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // bin_count[23:0], cumulative_count[47:24], channel_min[56:48],
  // channel_max[65:57], peak_count[89:66], pixel_total[113:90], zeros above
  output logic [119:0]      out_tdata
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PIX, S_QRY, S_FIN, S_FDONE
  } state_t;

  state_t state_r;
  bin_t   clr_idx_r;
  bin_t   pix_addr_r [CHANNELS];
  logic [1:0] qch_r;
  logic [BIN_W:0] fin_rd_r;
  logic   fin_vld_r;
  bin_t   fin_wa_r;
  count_t run_r   [CHANNELS];
  count_t chpk_r  [CHANNELS];
  ext_t   min_r   [CHANNELS];
  ext_t   max_r   [CHANNELS];
  count_t peak_r;
  count_t pix_r;
  logic   out_tvalid_r;
  logic [119:0] out_tdata_r;

  logic   in_xfer;
  op_t    in_op;
  bin_t   comp_bin [CHANNELS];
  bin_t   q_bin;
  logic   bin_we;
  bin_t   bin_waddr;
  bin_t   bin_raddr [CHANNELS];
  count_t bin_wdata [CHANNELS];
  count_t bin_rdata [CHANNELS];
  logic   cum_we;
  bin_t   cum_waddr;
  count_t cum_wdata [CHANNELS];
  count_t cum_rdata [CHANNELS];
  count_t run_nxt   [CHANNELS];
  count_t pk01;
  ext_t   qmin;
  ext_t   qmax;

  assign in_op   = op_t'(in_tuser[1:0]);
  assign q_bin   = bin_of(in_tdata[31:24]);
  assign comp_bin[0] = bin_of(in_tdata[7:0]);
  assign comp_bin[1] = bin_of(in_tdata[15:8]);
  assign comp_bin[2] = bin_of(in_tdata[23:16]);

  // Accept while idle and the result register is free or draining
  assign in_tready = (state_r == S_IDLE) && !(out_tvalid_r && !out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  // RAM port control
  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = pix_addr_r[0];
    cum_we    = 1'b0;
    cum_waddr = fin_wa_r;
    for (int c = 0; c < CHANNELS; c++) begin
      bin_raddr[c] = fin_rd_r[BIN_W-1:0];
      bin_wdata[c] = sat_add(bin_rdata[c], COUNT_BITS'(1));
      cum_wdata[c] = run_nxt[c];
      if (state_r == S_IDLE) begin
        bin_raddr[c] = (in_op == OP_PIXEL) ? comp_bin[c] : q_bin;
      end
    end
    case (state_r)
      S_CLR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_idx_r;
        cum_we    = 1'b1;
        cum_waddr = clr_idx_r;
        for (int c = 0; c < CHANNELS; c++) begin
          bin_wdata[c] = '0;
          cum_wdata[c] = '0;
        end
      end
      S_PIX: begin
        bin_we = 1'b1;
      end
      S_FIN: begin
        cum_we = fin_vld_r;
      end
      default: begin
      end
    endcase
  end

  // Running sums of the finalize walk
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      run_nxt[c] = sat_add(run_r[c], bin_rdata[c]);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_ch
      tche_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr ((state_r == S_PIX) ? pix_addr_r[g] : bin_waddr),
        .wdata (bin_wdata[g]),
        .raddr (bin_raddr[g]),
        .rdata (bin_rdata[g])
      );
      tche_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_cum_ram (
        .clk   (clk),
        .we    (cum_we),
        .waddr (cum_waddr),
        .wdata (cum_wdata[g]),
        .raddr (q_bin),
        .rdata (cum_rdata[g])
      );
    end
  endgenerate

  assign pk01 = (chpk_r[1] > chpk_r[0]) ? chpk_r[1] : chpk_r[0];
  assign qmin = min_r[qch_r];
  assign qmax = max_r[qch_r];

  // State machine and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
      fin_vld_r    <= 1'b0;
      fin_rd_r     <= '0;
      peak_r       <= '0;
      pix_r        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        min_r[c] <= EMPTY_BIN;
        max_r[c] <= EMPTY_BIN;
      end
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == BIN_W'(NUM_BINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            case (in_op)
              OP_CLEAR: begin
                state_r   <= S_CLR;
                clr_idx_r <= '0;
                peak_r    <= '0;
                pix_r     <= '0;
                for (int c = 0; c < CHANNELS; c++) begin
                  min_r[c] <= EMPTY_BIN;
                  max_r[c] <= EMPTY_BIN;
                end
              end
              OP_PIXEL: begin
                state_r <= S_PIX;
                pix_r   <= sat_add(pix_r, COUNT_BITS'(1));
                for (int c = 0; c < CHANNELS; c++) begin
                  pix_addr_r[c] <= comp_bin[c];
                end
              end
              OP_FINALIZE: begin
                state_r   <= S_FIN;
                fin_rd_r  <= '0;
                fin_vld_r <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                  run_r[c]  <= '0;
                  chpk_r[c] <= '0;
                  min_r[c]  <= EMPTY_BIN;
                  max_r[c]  <= EMPTY_BIN;
                end
              end
              default: begin
                state_r <= S_QRY;
                qch_r   <= (in_tuser[3:2] == 2'd0) ? 2'd0 : in_tuser[3:2] - 2'd1;
              end
            endcase
          end
        end
        S_PIX: begin
          state_r <= S_IDLE;
        end
        S_QRY: begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= {6'd0, pix_r, peak_r, qmax, qmin,
                           cum_rdata[qch_r], bin_rdata[qch_r]};
          state_r      <= S_IDLE;
        end
        S_FIN: begin
          // Issue reads, then fold each returned bin in the cycle after its read
          fin_vld_r <= !fin_rd_r[BIN_W];
          fin_wa_r  <= fin_rd_r[BIN_W-1:0];
          if (!fin_rd_r[BIN_W]) begin
            fin_rd_r <= fin_rd_r + 1'b1;
          end
          if (fin_vld_r) begin
            for (int c = 0; c < CHANNELS; c++) begin
              run_r[c] <= run_nxt[c];
              if (bin_rdata[c] > chpk_r[c]) begin
                chpk_r[c] <= bin_rdata[c];
              end
              if (bin_rdata[c] != '0) begin
                if (min_r[c] == EMPTY_BIN) begin
                  min_r[c] <= ext_t'({1'b0, fin_wa_r});
                end
                max_r[c] <= ext_t'({1'b0, fin_wa_r});
              end
            end
          end else if (fin_rd_r[BIN_W]) begin
            state_r <= S_FDONE;
          end
        end
        S_FDONE: begin
          peak_r  <= (chpk_r[2] > pk01) ? chpk_r[2] : pk01;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  // A result appears only after a query lookup
  a_res_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_QRY))
    else $error("result without query");

  // An accepted pixel is written back in the next cycle
  a_pix_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_op == OP_PIXEL) |=> bin_we)
    else $error("pixel write-back missing");

  // No item is taken during the clearing sweep
  a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("item taken while clearing");

  // Cumulative RAMs are written only by clear or finalize
  a_cum_write: assert property (@(posedge clk) disable iff (!rst_n)
    cum_we |-> (state_r == S_CLR || state_r == S_FIN))
    else $error("stray cumulative write");
`endif

endmodule
`default_nettype wire
